### design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, switched off while reset is asserted.
`define SOBM_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sobm assertion failed");

// Concurrent assertion that is also checked while reset is asserted.
`define SOBM_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("sobm reset assertion failed");

`endif

### design/sobm_pkg.sv
package sobm_pkg;

  // Pixel and register widths
  localparam int unsigned PIX_W     = 8;
  localparam int unsigned CFG_W     = 12;
  localparam int unsigned CFG_IDX_W = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = 2'd1;

  // Register reset values
  localparam logic [CFG_W-1:0] DEF_FRAME_COLS = 12'd640;
  localparam logic [CFG_W-1:0] DEF_FRAME_ROWS = 12'd480;

  // Default frame limits
  localparam int unsigned MAX_COLS_DEF = 2048;
  localparam int unsigned MAX_ROWS_DEF = 2048;

  // Smallest frame dimension
  localparam int unsigned MIN_DIM = 3;

  // Gray conversion: floor(sum / 3) as (sum * 2731) >> 13, exact for sum <= 765
  localparam int unsigned SUM_W      = PIX_W + 2;
  localparam int unsigned DIV3_MUL   = 2731;
  localparam int unsigned DIV3_SHIFT = 13;
  localparam int unsigned PROD_W     = SUM_W + 12;

  // Sobel gradient widths and the saturation limit
  localparam int unsigned GRAD_W   = PIX_W + 3;
  localparam int unsigned MAG_W    = PIX_W + 3;
  localparam int unsigned EDGE_MAX = 255;

  // Per-item control travelling with the pixel through the pipeline
  typedef struct packed {
    logic emit;
    logic border;
    logic last;
  } sobm_tag_t;

endpackage

### design/sobm_ram.sv
module sobm_ram
  import sobm_pkg::*;
#(
  parameter int unsigned WIDTH = 2 * PIX_W,
  parameter int unsigned DEPTH = MAX_COLS_DEF,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port; the read port returns the old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/sobel_edge_magnitude_3x3.sv
// Channel   Direction  Handshake                Payload
// input     in         in_valid_i / in_ready_o  chan_a_i, chan_b_i, chan_c_i, pad_i
// result    out        out_valid_o/out_ready_i  edge_res_o, frame_end_o
// config    in         cfg_we_i (no wait)       cfg_idx_i, cfg_data_i
//
// One item per cycle sustained unless the output stalls; results pass stage 1, stage 2 and
// the output register. The rate is set by the line RAM: each item reads its column at accept
// and writes it back as it leaves stage 1, with a bypass when the next item reads it.
// Reset clears the counters, window and pipeline; the line RAM is not cleared.
// in_ready_o drops only when all pipeline stages hold items and the output is stalled.
module sobel_edge_magnitude_3x3
  import sobm_pkg::*;
#(
  parameter int unsigned MAX_COLS = MAX_COLS_DEF,
  parameter int unsigned MAX_ROWS = MAX_ROWS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [PIX_W-1:0]     chan_a_i,
  input  logic [PIX_W-1:0]     chan_b_i,
  input  logic [PIX_W-1:0]     chan_c_i,
  input  logic                 pad_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [PIX_W-1:0]     edge_res_o,
  output logic                 frame_end_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  localparam int unsigned ICW = $clog2(MAX_COLS);
  localparam int unsigned CW  = ICW + 1;
  localparam int unsigned ORW = $clog2(MAX_ROWS);
  localparam int unsigned RW  = ORW + 1;
  localparam int unsigned IRW = $clog2(MAX_ROWS + 3);
  localparam int unsigned LW  = 2 * PIX_W;

  // Configuration registers
  logic [CFG_W-1:0] frame_cols_q, frame_rows_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_cols_q <= DEF_FRAME_COLS;
      frame_rows_q <= DEF_FRAME_ROWS;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FRAME_COLS: frame_cols_q <= cfg_data_i;
        REG_FRAME_ROWS: frame_rows_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp the frame size to the supported range
  logic [CW-1:0] cols;
  logic [RW-1:0] rows;

  always_comb begin
    if (frame_cols_q < CFG_W'(MIN_DIM)) begin
      cols = CW'(MIN_DIM);
    end else if (32'(frame_cols_q) > MAX_COLS) begin
      cols = CW'(MAX_COLS);
    end else begin
      cols = CW'(frame_cols_q);
    end
    if (frame_rows_q < CFG_W'(MIN_DIM)) begin
      rows = RW'(MIN_DIM);
    end else if (32'(frame_rows_q) > MAX_ROWS) begin
      rows = RW'(MAX_ROWS);
    end else begin
      rows = RW'(frame_rows_q);
    end
  end

  // Pipeline flow control
  logic      in_acc;
  logic      out_valid_q;
  logic      s1_v_q, s2_v_q;
  sobm_tag_t s1_tag_q;
  logic      out_free, s2_free, s1_leave, s1_free, s2_load, s2_leave;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s2_free    = !s2_v_q || out_free;
  assign s1_leave   = s1_v_q && (!s1_tag_q.emit || s2_free);
  assign s1_free    = !s1_v_q || s1_leave;
  assign s2_load    = s1_leave && s1_tag_q.emit;
  assign s2_leave   = s2_v_q && out_free;
  assign in_ready_o = s1_free;
  assign in_acc     = in_valid_i && s1_free;

  // Stream position counters
  logic [ICW-1:0] in_col_q, in_col_d, out_col_q, out_col_d, col_eff;
  logic [IRW-1:0] in_row_q, in_row_d;
  logic [ORW-1:0] out_row_q, out_row_d;
  logic [CW-1:0]  col_inc, ocol_inc, cols_m1;
  logic [RW-1:0]  rows_m1;
  sobm_tag_t      tag_d;

  always_comb begin
    cols_m1  = cols - CW'(1);
    rows_m1  = rows - RW'(1);
    col_eff  = ({1'b0, in_col_q} >= cols) ? '0 : in_col_q;
    col_inc  = {1'b0, col_eff} + CW'(1);
    ocol_inc = {1'b0, out_col_q} + CW'(1);

    tag_d.emit   = (in_row_q > IRW'(1)) || (in_row_q == IRW'(1) && col_eff != '0);
    tag_d.border = (out_row_q == '0) || ({1'b0, out_row_q} >= rows_m1) ||
                   (out_col_q == '0) || ({1'b0, out_col_q} >= cols_m1);
    tag_d.last   = ({1'b0, out_row_q} >= rows_m1) && ({1'b0, out_col_q} >= cols_m1);

    // advance the input position
    in_row_d = in_row_q;
    if (col_inc >= cols) begin
      in_col_d = '0;
      if (in_row_q < IRW'(MAX_ROWS + 2)) begin
        in_row_d = in_row_q + IRW'(1);
      end
    end else begin
      in_col_d = col_inc[ICW-1:0];
    end

    // advance the output position, or close the frame
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (tag_d.emit) begin
      if (tag_d.last) begin
        in_col_d  = '0;
        in_row_d  = '0;
        out_col_d = '0;
        out_row_d = '0;
      end else if (ocol_inc >= cols) begin
        out_col_d = '0;
        out_row_d = out_row_q + ORW'(1);
      end else begin
        out_col_d = ocol_inc[ICW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else if (in_acc) begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
    end
  end

  // Gray value: channel sum divided by three, zero for a pad item
  logic [SUM_W-1:0]  chan_sum;
  logic [PROD_W-1:0] gray_prod;
  logic [PIX_W-1:0]  gray_d;

  assign chan_sum  = SUM_W'(chan_a_i) + SUM_W'(chan_b_i) + SUM_W'(chan_c_i);
  assign gray_prod = PROD_W'(chan_sum) * PROD_W'(DIV3_MUL);
  assign gray_d    = pad_i ? '0 : gray_prod[DIV3_SHIFT +: PIX_W];

  // Line RAM: upper row in the high byte, middle row in the low byte
  logic           ram_we;
  logic [ICW-1:0] s1_col_q;
  logic [LW-1:0]  ram_wdata, ram_rdata, line_cur;
  logic [PIX_W-1:0] s1_gray_q, up_cur, mid_cur;
  logic           s1_byp_q;
  logic [LW-1:0]  s1_byp_data_q;

  assign line_cur  = s1_byp_q ? s1_byp_data_q : ram_rdata;
  assign up_cur    = line_cur[LW-1:PIX_W];
  assign mid_cur   = line_cur[PIX_W-1:0];
  assign ram_we    = s1_leave;
  assign ram_wdata = {mid_cur, s1_gray_q};

  sobm_ram #(
    .WIDTH(LW),
    .DEPTH(MAX_COLS)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(s1_col_q),
    .wdata_i(ram_wdata),
    .re_i   (in_acc),
    .raddr_i(col_eff),
    .rdata_o(ram_rdata)
  );

  // Stage 1 valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s1_free) begin
      s1_v_q <= in_acc;
    end
  end

  // Stage 1 payload; capture the write-back when it hits the column just read
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_col_q      <= col_eff;
      s1_gray_q     <= gray_d;
      s1_tag_q      <= tag_d;
      s1_byp_q      <= ram_we && (s1_col_q == col_eff);
      s1_byp_data_q <= ram_wdata;
    end
  end

  // 3x3 window: shift left, new column from the line RAM and the new gray
  logic [PIX_W-1:0] win_q [3][3];
  logic [PIX_W-1:0] win_d [3][3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_d[r][0] = win_q[r][1];
      win_d[r][1] = win_q[r][2];
    end
    win_d[0][2] = up_cur;
    win_d[1][2] = mid_cur;
    win_d[2][2] = s1_gray_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_q[r][c] <= '0;
        end
      end
    end else if (s1_leave) begin
      win_q <= win_d;
    end
  end

  // Sobel gradients from the updated window
  logic [SUM_W-1:0]         gx_pos, gx_neg, gy_pos, gy_neg;
  logic signed [GRAD_W-1:0] gx_d, gy_d, gx_q, gy_q;

  always_comb begin
    gx_pos = SUM_W'(win_d[0][0]) + {1'b0, win_d[1][0], 1'b0} + SUM_W'(win_d[2][0]);
    gx_neg = SUM_W'(win_d[0][2]) + {1'b0, win_d[1][2], 1'b0} + SUM_W'(win_d[2][2]);
    gy_pos = SUM_W'(win_d[0][0]) + {1'b0, win_d[0][1], 1'b0} + SUM_W'(win_d[0][2]);
    gy_neg = SUM_W'(win_d[2][0]) + {1'b0, win_d[2][1], 1'b0} + SUM_W'(win_d[2][2]);
    gx_d   = $signed({1'b0, gx_pos}) - $signed({1'b0, gx_neg});
    gy_d   = $signed({1'b0, gy_pos}) - $signed({1'b0, gy_neg});
  end

  // Stage 2: gradients and flags of an item that yields a result
  logic s2_border_q, s2_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (s2_load) begin
      s2_v_q <= 1'b1;
    end else if (s2_leave) begin
      s2_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      gx_q        <= gx_d;
      gy_q        <= gy_d;
      s2_border_q <= s1_tag_q.border;
      s2_last_q   <= s1_tag_q.last;
    end
  end

  // L1 magnitude, saturated; zero for a border pixel
  logic [GRAD_W-1:0] gx_abs, gy_abs;
  logic [MAG_W-1:0]  mag;
  logic [PIX_W-1:0]  edge_d;

  always_comb begin
    gx_abs = gx_q[GRAD_W-1] ? GRAD_W'(-gx_q) : GRAD_W'(gx_q);
    gy_abs = gy_q[GRAD_W-1] ? GRAD_W'(-gy_q) : GRAD_W'(gy_q);
    mag    = MAG_W'(gx_abs) + MAG_W'(gy_abs);
    if (s2_border_q) begin
      edge_d = '0;
    end else if (mag > MAG_W'(EDGE_MAX)) begin
      edge_d = PIX_W'(EDGE_MAX);
    end else begin
      edge_d = mag[PIX_W-1:0];
    end
  end

  // Output register: hold while the consumer stalls
  logic [PIX_W-1:0] edge_q;
  logic             frame_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s2_leave;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_leave) begin
      edge_q      <= edge_d;
      frame_end_q <= s2_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign edge_res_o  = edge_q;
  assign frame_end_o = frame_end_q;

endmodule

### design/sobm_checker.sv
`include "assert_macros.svh"

module sobm_checker
  import sobm_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [PIX_W-1:0] edge_res_o,
  input logic             frame_end_o
);

  // A stalled result holds its value
  `SOBM_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(edge_res_o) && $stable(frame_end_o))

  // The last pixel of a frame is a corner and reads zero
  `SOBM_ASSERT(a_end_is_border, clk_i, rst_ni, out_valid_o && frame_end_o |-> edge_res_o == '0)

  // Input stalls only behind a stalled result
  `SOBM_ASSERT(a_in_stall, clk_i, rst_ni, in_valid_i && !in_ready_o |-> out_valid_o && !out_ready_i)

  // No result is shown just after reset
  `SOBM_ASSERT_RST(a_rst_idle, clk_i, !rst_ni |=> !out_valid_o)

endmodule

bind sobel_edge_magnitude_3x3 sobm_checker u_sobm_checker (.*);
